// ----- rtl/core/tmps_pkg.sv -----
package tmps_pkg;

  localparam int DATA_BITS    = 16;
  localparam int SUM_BITS     = 26;
  localparam int MAX_ROWS_DEF = 1024;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] value;
    logic                        row_end;
    logic                        triangle_end;
  } in_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] min_sum;
    logic                       shape_error;
  } out_t;

  // one entry on its way from the sequencer to the accumulate stage
  typedef struct packed {
    logic                        valid;
    logic signed [DATA_BITS-1:0] value;
    logic                        first;     // column zero of its row
    logic                        has_left;
    logic                        has_up;
    logic                        wr_en;     // column lies inside the row store
    logic                        row_done;
    logic                        tri_end;
    logic                        err;       // sticky shape error including this entry
  } op_t;

endpackage

// ----- rtl/core/tmps_row_mem.sv -----
module tmps_row_mem #(
  parameter int DEPTH = tmps_pkg::MAX_ROWS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [tmps_pkg::SUM_BITS-1:0] wr_data,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [tmps_pkg::SUM_BITS-1:0] rd_data
);

  logic signed [tmps_pkg::SUM_BITS-1:0] mem [DEPTH];
  logic signed [tmps_pkg::SUM_BITS-1:0] q_r;
  logic signed [tmps_pkg::SUM_BITS-1:0] byp_data_r;
  logic                                 byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first array; bypass the word written in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

// ----- rtl/core/tmps_seq.sv -----
module tmps_seq #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF,
  parameter int AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  tmps_pkg::in_t    in_item,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  output logic [AW-1:0]    wr_addr,
  output tmps_pkg::op_t    op
);

  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ROWS);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          err_r, err_nxt;
  tmps_pkg::op_t op_r, op_nxt;
  logic [AW-1:0] wr_addr_r;

  logic [CW-1:0] col_inc;
  logic [CW-1:0] row_inc;
  logic          in_store;
  logic          ends_row;
  logic          len_bad;
  logic          err_now;

  always_comb begin
    in_store = (col_r < MAX_C);
    col_inc  = in_store ? col_r + 1'b1 : col_r;
    row_inc  = (row_r < MAX_C) ? row_r + 1'b1 : row_r;
    ends_row = in_item.row_end | in_item.triangle_end;
    len_bad  = ends_row && ({1'b0, col_inc} != ({1'b0, row_r} + 1'b1));
    err_now  = (row_r >= MAX_C) | len_bad;

    op_nxt          = op_r;
    op_nxt.valid    = accept;
    col_nxt         = col_r;
    row_nxt         = row_r;
    err_nxt         = err_r;
    if (accept) begin
      op_nxt.value    = in_item.value;
      op_nxt.first    = (col_r == '0);
      op_nxt.has_left = (col_r != '0) && (col_r <= row_r);
      op_nxt.has_up   = (row_r != '0) && (col_r < row_r) && in_store;
      op_nxt.wr_en    = in_store;
      op_nxt.row_done = ends_row;
      op_nxt.tri_end  = in_item.triangle_end;
      op_nxt.err      = err_r | err_now;
      if (in_item.triangle_end) begin
        col_nxt = '0;
        row_nxt = '0;
        err_nxt = 1'b0;
      end else if (in_item.row_end) begin
        col_nxt = '0;
        row_nxt = row_inc;
        err_nxt = err_r | err_now;
      end else begin
        col_nxt = col_inc;
        err_nxt = err_r | err_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      err_r      <= 1'b0;
      op_r.valid <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      err_r      <= err_nxt;
      op_r.valid <= op_nxt.valid;
    end
    op_r.value    <= op_nxt.value;
    op_r.first    <= op_nxt.first;
    op_r.has_left <= op_nxt.has_left;
    op_r.has_up   <= op_nxt.has_up;
    op_r.wr_en    <= op_nxt.wr_en;
    op_r.row_done <= op_nxt.row_done;
    op_r.tri_end  <= op_nxt.tri_end;
    op_r.err      <= op_nxt.err;
    if (accept) begin
      wr_addr_r <= col_r[AW-1:0];
    end
  end

  assign rd_en   = accept & in_store;
  assign rd_addr = col_r[AW-1:0];
  assign wr_addr = wr_addr_r;
  assign op      = op_r;

endmodule

// ----- rtl/core/tmps_accum.sv -----
module tmps_accum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tmps_pkg::op_t                        op,
  input  logic signed [tmps_pkg::SUM_BITS-1:0] rd_data,
  output logic                                 wr_en,
  output logic signed [tmps_pkg::SUM_BITS-1:0] wr_data,
  output logic                                 res_full,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tmps_pkg::out_t                       out_data
);

  localparam int SB = tmps_pkg::SUM_BITS;
  localparam int DB = tmps_pkg::DATA_BITS;

  logic signed [SB-1:0] left_r, left_nxt;
  logic signed [SB-1:0] rmin_r, rmin_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tmps_pkg::out_t       out_data_r, out_data_nxt;
  logic                 spare_valid_r, spare_valid_nxt;
  tmps_pkg::out_t       spare_data_r, spare_data_nxt;

  logic signed [SB-1:0] addend;
  logic signed [SB:0]   sum_w;
  logic signed [SB-1:0] best;
  logic signed [SB-1:0] rmin_upd;
  logic                 res_new;
  logic                 pop;
  tmps_pkg::out_t       res_item;

  always_comb begin
    if (op.has_left && op.has_up) begin
      addend = (left_r < rd_data) ? left_r : rd_data;
    end else if (op.has_left) begin
      addend = left_r;
    end else if (op.has_up) begin
      addend = rd_data;
    end else begin
      addend = '0;
    end
    sum_w = {{(SB + 1 - DB){op.value[DB-1]}}, op.value} + {addend[SB-1], addend};
    // saturate to the sum range
    if (sum_w[SB] != sum_w[SB-1]) begin
      best = sum_w[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      best = sum_w[SB-1:0];
    end
    rmin_upd = (op.first || (best < rmin_r)) ? best : rmin_r;

    res_new              = op.valid & op.tri_end;
    res_item.min_sum     = rmin_upd;
    res_item.shape_error = op.err;
    pop                  = out_valid_r & ~out_stall;

    left_nxt = left_r;
    rmin_nxt = rmin_r;
    if (op.valid) begin
      rmin_nxt = rmin_upd;
      if (op.row_done) begin
        left_nxt = '0;
      end else if (op.wr_en) begin
        left_nxt = rd_data;
      end
      if (op.tri_end) begin
        left_nxt = '0;
        rmin_nxt = '0;
      end
    end

    // two-entry result queue: head drives the port, spare catches a result
    // that arrives while the head is held
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    spare_valid_nxt = spare_valid_r;
    spare_data_nxt  = spare_data_r;
    if (pop) begin
      out_valid_nxt   = spare_valid_r;
      out_data_nxt    = spare_data_r;
      spare_valid_nxt = 1'b0;
    end
    if (res_new) begin
      if (out_valid_nxt) begin
        spare_valid_nxt = 1'b1;
        spare_data_nxt  = res_item;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r        <= '0;
      rmin_r        <= '0;
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      left_r        <= left_nxt;
      rmin_r        <= rmin_nxt;
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    spare_data_r <= spare_data_nxt;
  end

  // a new triangle end would find both result registers still taken
  assign res_full  = (spare_valid_r & (out_stall | res_new)) |
                     (out_valid_r & out_stall & res_new);
  assign wr_en     = op.valid & op.wr_en;
  assign wr_data   = best;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/triangle_min_path_sum.sv -----
// Channel | Ports                        | Transfer when         | Payload
// --------+------------------------------+-----------------------+------------------------------
// input   | in_valid in_stall in_data    | in_valid & !in_stall  | value, row_end, triangle_end
// result  | out_valid out_stall out_data | out_valid & !out_stall| min_sum, shape_error
//
// One entry is taken every cycle while in_stall is low; the rate is set by
// the single read and single write of the row store per entry. The entry
// ending the triangle passes the sequencer register, then sets out_valid.
// Reset (rst_n low, synchronous) clears counters, error flag, pipeline and
// both result registers; the row store is not cleared.
// in_stall rises only for an entry that ends a triangle, while both result
// registers are taken, or about to be, by results held back by out_stall.
module triangle_min_path_sum #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tmps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tmps_pkg::out_t out_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic                                 accept;
  logic                                 rd_en;
  logic [AW-1:0]                        rd_addr;
  logic [AW-1:0]                        wr_addr;
  logic                                 wr_en;
  logic signed [tmps_pkg::SUM_BITS-1:0] wr_data;
  logic signed [tmps_pkg::SUM_BITS-1:0] rd_data;
  logic                                 res_full;
  tmps_pkg::op_t                        op;

  // hold a triangle end back until a result register is sure to be free
  // when it reaches the accumulate stage
  assign in_stall = in_data.triangle_end & res_full;
  assign accept   = in_valid & ~in_stall;

  // stage 0: column and row counting, store read issue
  tmps_seq #(
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .op      (op)
  );

  // row store of best path sums, bypass on same-column read and write
  tmps_row_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // stage 1: add, saturate, write back, track row minimum, queue result
  tmps_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .res_full  (res_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
